// File: rtl/mwlfo_pkg.sv
// ----------------------------------------------------------------------------
// mwlfo_pkg
// Shared types, constants and table functions of the multiwave LFO.
// ----------------------------------------------------------------------------
`default_nettype none

package mwlfo_pkg;

  localparam int unsigned DEF_PHASE_BITS      = 32;
  localparam int unsigned DEF_TABLE_ADDR_BITS = 10;
  localparam int unsigned DEF_OUT_BITS        = 16;

  localparam int unsigned INC_BITS      = 32;
  localparam int unsigned WAVE_BITS     = 3;
  localparam int unsigned COUNT_BITS    = 16;
  localparam int unsigned CMD_BITS      = 2;
  localparam int unsigned WEIGHT_BITS   = 16;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_INC = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_WAVEFORM  = CFG_IDX_BITS'(1);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_EMIT    = 2'd0,
    CMD_SKIP    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_PEEK    = 2'd3
  } cmd_e;

  typedef enum logic [WAVE_BITS-1:0] {
    WAVE_TRI         = 3'd0,
    WAVE_SQUARE      = 3'd1,
    WAVE_SAW         = 3'd2,
    WAVE_RAMP_DOWN   = 3'd3,
    WAVE_SAMPLE_HOLD = 3'd4,
    WAVE_SMOOTH      = 3'd5,
    WAVE_EXP         = 3'd6,
    WAVE_SINE        = 3'd7
  } wave_e;

  // 32-bit LCG
  localparam logic [31:0] LCG_MUL    = 32'd1664525;
  localparam logic [31:0] LCG_ADD    = 32'd1013904223;
  localparam logic [31:0] LCG_SEED   = 32'h01234567;
  localparam logic [31:0] LCG_STATE1 = LCG_SEED * LCG_MUL + LCG_ADD;
  localparam logic [31:0] LCG_STATE2 = LCG_STATE1 * LCG_MUL + LCG_ADD;

  localparam longint unsigned Q30_ONE    = 64'd1 << 30;
  localparam longint unsigned Q30_HALF   = 64'd1 << 29;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  // sin(x), x in Q30 within [0, pi/2], Taylor series
  function automatic longint unsigned sine_q30(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  // exp(-8z) as exp(-z) series squared three times, rounded each time
  function automatic longint unsigned exp_neg_q30(longint unsigned z);
    longint unsigned term;
    longint unsigned sum;
    term = Q30_ONE;
    sum  = Q30_ONE;
    for (int k = 1; k <= 10; k++) begin
      term = ((term * z) >> 30) / 64'(k);
      if ((k & 1) != 0) sum = sum - term;
      else sum = sum + term;
    end
    for (int n = 0; n < 3; n++) begin
      sum = (sum * sum + Q30_HALF) >> 30;
    end
    return sum;
  endfunction

  function automatic longint sat_level(longint v, int unsigned obits);
    longint fs;
    fs = longint'(1) << (obits - 1);
    if (v > fs - 1) return fs - 1;
    if (v < -fs) return -fs;
    return v;
  endfunction

  function automatic longint sine_entry(int unsigned i, int unsigned abits,
                                        int unsigned obits);
    longint unsigned quarter;
    longint unsigned quad;
    longint unsigned j;
    longint unsigned k;
    longint unsigned x;
    longint unsigned fs;
    longint          m;
    quarter = 64'd1 << (abits - 2);
    quad    = 64'(i) >> (abits - 2);
    j       = 64'(i) & (quarter - 1);
    k       = quad[0] ? quarter - j : j;
    x       = (TWO_PI_Q30 * k) >> abits;
    fs      = 64'd1 << (obits - 1);
    m       = longint'((sine_q30(x) * fs + Q30_HALF) >> 30);
    return sat_level((quad >= 2) ? -m : m, obits);
  endfunction

  function automatic longint exp_entry(int unsigned i, int unsigned abits,
                                       int unsigned obits);
    longint unsigned z;
    longint unsigned fs;
    longint          v;
    z  = (64'd3 * 64'(i)) << (27 - abits);
    fs = 64'd1 << (obits - 1);
    v  = longint'((exp_neg_q30(z) * (2 * fs) + Q30_HALF) >> 30);
    return sat_level(v - longint'(fs), obits);
  endfunction

endpackage

`default_nettype wire

// File: rtl/mwlfo_if.sv
// ----------------------------------------------------------------------------
// mwlfo_if
// Request and result channels of the multiwave LFO (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface mwlfo_cmd_if
  import mwlfo_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CMD_BITS-1:0]   command;
  logic [COUNT_BITS-1:0] skip_count;

  modport source (output valid, command, skip_count, input ready);
  modport sink   (input valid, command, skip_count, output ready);
endinterface

interface mwlfo_lvl_if
  import mwlfo_pkg::*;
  #(parameter int unsigned OUT_BITS = DEF_OUT_BITS) ();
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] level;

  modport source (output valid, level, input ready);
  modport sink   (input valid, level, output ready);
endinterface

`default_nettype wire

// File: rtl/mwlfo_fifo.sv
// ----------------------------------------------------------------------------
// mwlfo_fifo
// Short request queue between front end and execution core.
// ----------------------------------------------------------------------------
`default_nettype none

module mwlfo_fifo
  import mwlfo_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      rdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == FULL);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mwlfo_front.sv
// ----------------------------------------------------------------------------
// mwlfo_front
// Accepts requests, decodes the command and forms the phase step.
// ----------------------------------------------------------------------------
`default_nettype none

module mwlfo_front
  import mwlfo_pkg::*;
#(
  parameter int unsigned PHASE_BITS = DEF_PHASE_BITS
) (
  mwlfo_cmd_if.sink                         cmd_i,
  input  wire logic [INC_BITS-1:0]          inc_i,
  input  wire logic                         q_full_i,
  output logic                              push_o,
  output cmd_e                              op_o,
  output logic [PHASE_BITS+COUNT_BITS-1:0]  step_o
);

  localparam int unsigned SW = PHASE_BITS + COUNT_BITS;

  logic [63:0]           inc_ext;
  logic [PHASE_BITS-1:0] inc_m;

  // increment taken modulo the phase range
  assign inc_ext = 64'(inc_i);
  assign inc_m   = inc_ext[PHASE_BITS-1:0];

  assign cmd_i.ready = !q_full_i;
  assign push_o      = cmd_i.valid && !q_full_i;
  assign op_o        = cmd_e'(cmd_i.command);

  // skip advances by increment * count in one step
  assign step_o = (op_o == CMD_SKIP) ? SW'(inc_m) * SW'(cmd_i.skip_count) : SW'(inc_m);

endmodule

`default_nettype wire

// File: rtl/mwlfo_core.sv
// ----------------------------------------------------------------------------
// mwlfo_core
// Executes queued requests: phase accumulator, LCG and random targets.
// ----------------------------------------------------------------------------
`default_nettype none

module mwlfo_core
  import mwlfo_pkg::*;
#(
  parameter int unsigned PHASE_BITS = DEF_PHASE_BITS,
  parameter int unsigned OUT_BITS   = DEF_OUT_BITS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                q_valid_i,
  input  wire cmd_e                                q_op_i,
  input  wire logic [PHASE_BITS+COUNT_BITS-1:0]    q_step_i,
  output logic                                     q_pop_o,
  input  wire logic                                s1_ready_i,
  output logic                                     take_o,
  output logic [PHASE_BITS-1:0]                    phase_o,
  output logic signed [OUT_BITS-1:0]               rand_cur_o,
  output logic signed [OUT_BITS-1:0]               rand_next_o
);

  localparam int unsigned SW = PHASE_BITS + COUNT_BITS;

  logic [PHASE_BITS-1:0]      phase_q, phase_d;
  logic [31:0]                lcg_q, lcg_d;
  logic signed [OUT_BITS-1:0] rcur_q, rcur_d;
  logic signed [OUT_BITS-1:0] rnext_q, rnext_d;
  logic [SW:0]                sum;
  logic [31:0]                lcg_step;
  logic                       has_result;
  logic                       fire;

  assign has_result = (q_op_i == CMD_EMIT) || (q_op_i == CMD_PEEK);
  // requests without a result never wait on the shaping pipeline
  assign fire    = q_valid_i && (!has_result || s1_ready_i);
  assign q_pop_o = fire;
  assign take_o  = fire && has_result;

  assign phase_o     = phase_q;
  assign rand_cur_o  = rcur_q;
  assign rand_next_o = rnext_q;

  assign sum      = (SW + 1)'(phase_q) + (SW + 1)'(q_step_i);
  assign lcg_step = lcg_q * LCG_MUL + LCG_ADD;

  always_comb begin
    phase_d = phase_q;
    lcg_d   = lcg_q;
    rcur_d  = rcur_q;
    rnext_d = rnext_q;
    if (fire) begin
      unique case (q_op_i)
        CMD_EMIT, CMD_SKIP: begin
          phase_d = sum[PHASE_BITS-1:0];
          // one wrap however many cycles passed
          if (|sum[SW:PHASE_BITS]) begin
            lcg_d   = lcg_step;
            rcur_d  = rnext_q;
            rnext_d = lcg_step[31 -: OUT_BITS];
          end
        end
        CMD_RESTART: begin
          phase_d = '0;
          lcg_d   = LCG_STATE2;
          rcur_d  = LCG_STATE1[31 -: OUT_BITS];
          rnext_d = LCG_STATE2[31 -: OUT_BITS];
        end
        CMD_PEEK: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      lcg_q   <= LCG_STATE2;
      rcur_q  <= LCG_STATE1[31 -: OUT_BITS];
      rnext_q <= LCG_STATE2[31 -: OUT_BITS];
    end else begin
      phase_q <= phase_d;
      lcg_q   <= lcg_d;
      rcur_q  <= rcur_d;
      rnext_q <= rnext_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mwlfo_shape.sv
// ----------------------------------------------------------------------------
// mwlfo_shape
// Waveform shaping: operand/table stage, then saturated output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mwlfo_shape
  import mwlfo_pkg::*;
#(
  parameter int unsigned PHASE_BITS      = DEF_PHASE_BITS,
  parameter int unsigned TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS,
  parameter int unsigned OUT_BITS        = DEF_OUT_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          take_i,
  input  wire logic [PHASE_BITS-1:0]         phase_i,
  input  wire logic signed [OUT_BITS-1:0]    rand_cur_i,
  input  wire logic signed [OUT_BITS-1:0]    rand_next_i,
  input  wire wave_e                         wave_i,
  output logic                               s1_ready_o,
  mwlfo_lvl_if.source                        lvl_o
);

  localparam int unsigned TBL = 1 << TABLE_ADDR_BITS;
  localparam int unsigned XW  = PHASE_BITS + OUT_BITS;
  localparam int unsigned LW  = OUT_BITS + 2;
  localparam int unsigned PW  = OUT_BITS + 1 + WEIGHT_BITS + 1;
  localparam logic signed [LW-1:0] FS =
    {2'b00, 1'b1, {(OUT_BITS - 1){1'b0}}};
  localparam logic [PHASE_BITS-1:0] HALF =
    {1'b1, {(PHASE_BITS - 1){1'b0}}};

  logic signed [OUT_BITS-1:0] sine_rom [TBL];
  logic signed [OUT_BITS-1:0] exp_rom  [TBL];

  for (genvar g = 0; g < TBL; g++) begin : g_rom
    assign sine_rom[g] = OUT_BITS'(sine_entry(g, TABLE_ADDR_BITS, OUT_BITS));
    assign exp_rom[g]  = OUT_BITS'(exp_entry(g, TABLE_ADDR_BITS, OUT_BITS));
  end

  logic                       s1_v_q;
  logic                       out_v_q;
  logic                       s1_en;
  logic                       out_en;
  logic [PHASE_BITS-1:0]      p1_q;
  logic signed [OUT_BITS-1:0] cur1_q;
  logic signed [OUT_BITS:0]   diff1_q;
  logic signed [OUT_BITS-1:0] rom1_q;
  logic signed [OUT_BITS-1:0] lvl_q;

  logic [TABLE_ADDR_BITS-1:0] idx;
  logic signed [OUT_BITS-1:0] rom_d;

  logic [PHASE_BITS-1:0]      mid_dist;
  logic [XW-1:0]              tri_x;
  logic [XW-1:0]              saw_x;
  logic signed [LW-1:0]       tri_v;
  logic signed [LW-1:0]       saw_v;
  logic [WEIGHT_BITS-1:0]     weight;
  logic signed [PW-1:0]       prod;
  logic signed [PW-1:0]       prod_sh;
  logic signed [LW-1:0]       smooth_v;
  logic signed [LW-1:0]       raw;
  logic signed [OUT_BITS-1:0] lvl_d;

  function automatic logic signed [OUT_BITS-1:0] sat(logic signed [LW-1:0] v);
    if (v > FS - LW'(1)) return OUT_BITS'(FS - LW'(1));
    if (v < -FS) return OUT_BITS'(-FS);
    return OUT_BITS'(v);
  endfunction

  assign out_en     = !out_v_q || lvl_o.ready;
  assign s1_en      = !s1_v_q || out_en;
  assign s1_ready_o = s1_en;

  assign idx   = phase_i[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  assign rom_d = (wave_i == WAVE_EXP) ? exp_rom[idx] : sine_rom[idx];

  // distance from mid-cycle for the triangle
  assign mid_dist = p1_q[PHASE_BITS-1] ? (p1_q & ~HALF) : (HALF - p1_q);
  assign tri_x    = (XW'(mid_dist) << (OUT_BITS - 1)) >> (PHASE_BITS - 2);
  assign saw_x    = (XW'(p1_q) << (OUT_BITS - 1)) >> (PHASE_BITS - 1);
  assign tri_v    = signed'(LW'(tri_x)) - FS;
  assign saw_v    = signed'(LW'(saw_x)) - FS;

  // interpolated random: cur + floor(diff * w / 2^16)
  assign weight   = p1_q[PHASE_BITS-1 -: WEIGHT_BITS];
  assign prod     = PW'(diff1_q) * signed'(PW'(weight));
  assign prod_sh  = prod >>> WEIGHT_BITS;
  assign smooth_v = LW'(cur1_q) + LW'(prod_sh);

  always_comb begin
    unique case (wave_i)
      WAVE_TRI:         raw = tri_v;
      WAVE_SQUARE:      raw = p1_q[PHASE_BITS-1] ? -FS : FS - LW'(1);
      WAVE_SAW:         raw = saw_v;
      WAVE_RAMP_DOWN:   raw = -saw_v;
      WAVE_SAMPLE_HOLD: raw = LW'(cur1_q);
      WAVE_SMOOTH:      raw = smooth_v;
      WAVE_EXP:         raw = LW'(rom1_q);
      WAVE_SINE:        raw = LW'(rom1_q);
    endcase
    lvl_d = sat(raw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_en) s1_v_q <= take_i;
      if (out_en) out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && take_i) begin
      p1_q    <= phase_i;
      cur1_q  <= rand_cur_i;
      diff1_q <= (OUT_BITS + 1)'(rand_next_i) - (OUT_BITS + 1)'(rand_cur_i);
      rom1_q  <= rom_d;
    end
    if (out_en && s1_v_q) begin
      lvl_q <= lvl_d;
    end
  end

  assign lvl_o.valid = out_v_q;
  assign lvl_o.level = lvl_q;

endmodule

`default_nettype wire

// File: rtl/multiwave_lfo.sv
// Path: an accepted request passes the queue write, the operand/table stage
//   and the output register before its level reaches the output.
// Throughput: one request per cycle unless the output stalls; phase/LCG registered on pop.
// Reset: phase 0, LCG seeded and stepped twice, increment 0, sine selected.
//   No clearing pass; requests are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
// multiwave_lfo
// Phase-accumulator LFO with eight waveforms and LCG random targets.
// ----------------------------------------------------------------------------
`default_nettype none

module multiwave_lfo
  import mwlfo_pkg::*;
#(
  parameter int unsigned PHASE_BITS      = DEF_PHASE_BITS,
  parameter int unsigned TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS,
  parameter int unsigned OUT_BITS        = DEF_OUT_BITS
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i,
  mwlfo_cmd_if.sink                     cmd_i,
  mwlfo_lvl_if.source                   lvl_o
);

  localparam int unsigned SW = PHASE_BITS + COUNT_BITS;
  localparam int unsigned QW = CMD_BITS + SW;

  logic [INC_BITS-1:0]        inc_q;
  wave_e                      wave_q;

  logic                       push;
  cmd_e                       f_op;
  logic [SW-1:0]              f_step;
  logic                       q_full;
  logic                       q_valid;
  logic                       q_pop;
  logic [QW-1:0]              q_rdata;
  cmd_e                       q_op;
  logic [SW-1:0]              q_step;
  logic                       s1_ready;
  logic                       take;
  logic [PHASE_BITS-1:0]      phase;
  logic signed [OUT_BITS-1:0] rand_cur;
  logic signed [OUT_BITS-1:0] rand_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q  <= '0;
      wave_q <= WAVE_SINE;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_PHASE_INC) inc_q <= cfg_data_i[INC_BITS-1:0];
      if (cfg_idx_i == REG_WAVEFORM) wave_q <= wave_e'(cfg_data_i[WAVE_BITS-1:0]);
    end
  end

  mwlfo_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .cmd_i    (cmd_i),
    .inc_i    (inc_q),
    .q_full_i (q_full),
    .push_o   (push),
    .op_o     (f_op),
    .step_o   (f_step)
  );

  mwlfo_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_op, f_step}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign q_op   = cmd_e'(q_rdata[QW-1 -: CMD_BITS]);
  assign q_step = q_rdata[SW-1:0];

  mwlfo_core #(
    .PHASE_BITS (PHASE_BITS),
    .OUT_BITS   (OUT_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (q_op),
    .q_step_i    (q_step),
    .q_pop_o     (q_pop),
    .s1_ready_i  (s1_ready),
    .take_o      (take),
    .phase_o     (phase),
    .rand_cur_o  (rand_cur),
    .rand_next_o (rand_next)
  );

  mwlfo_shape #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .OUT_BITS        (OUT_BITS)
  ) u_shape (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .phase_i     (phase),
    .rand_cur_i  (rand_cur),
    .rand_next_i (rand_next),
    .wave_i      (wave_q),
    .s1_ready_o  (s1_ready),
    .lvl_o       (lvl_o)
  );

`ifndef SYNTHESIS
  a_restart_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop && (q_op == CMD_RESTART) |=> (phase == '0))
    else $error("restart did not clear the phase");

  a_peek_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop && (q_op == CMD_PEEK) |=>
      $stable(phase) && $stable(rand_cur) && $stable(rand_next))
    else $error("peek changed oscillator state");

  a_skip_none : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop && (q_op == CMD_SKIP) && (q_step == '0) |=> $stable(phase))
    else $error("zero skip moved the phase");
`endif

endmodule

`default_nettype wire
